// ===== design/assert_macros.svh =====
// Assertion macros for the RTL; only tofm_dp includes them.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== design/tofm_pkg.sv =====
// Package for the timestamp ordered flow mux: sizes, codes, FSM state,
// controller/datapath command and status structs, wrap-aware time compare.
// No dependencies.
package tofm_pkg;

	localparam int FLOWS      = 8;
	localparam int RING_DEPTH = 8;
	localparam int TIME_W     = 24;
	localparam int PAY_W      = 32;
	localparam int FLOW_IN_W  = 3;
	localparam int SPACE_W    = 6;
	localparam int CNT_W      = 32;
	localparam int FLOW_W     = $clog2(FLOWS);
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int ADDR_W     = $clog2(FLOWS * RING_DEPTH);
	localparam int ENTRY_W    = TIME_W + PAY_W;
	localparam logic [TIME_W-1:0] WINDOW_RST = TIME_W'(4096);

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_MUX  = 1'b1;

	typedef enum logic [1:0] {
		KIND_MUXED = 2'd0,
		KIND_PUSH  = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH,
		ST_DROP,
		ST_DROP_WAIT,
		ST_SCAN_START,
		ST_SCAN,
		ST_PICK,
		ST_READ,
		ST_EMIT,
		ST_REFILL,
		ST_REFILL_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic cur_inc;
		logic cur_best;
		logic rd_cur;
		logic drop;
		logic set_elig;
		logic clr_elig;
		logic scan_clr;
		logic scan_step;
		logic emit;
		logic push_do;
		logic done_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_fire;
		logic in_is_mux;
		logic cur_empty;
		logic cur_last;
		logic head_keep;
		logic best_valid;
		logic space_left;
		logic out_free;
	} dp_stat_t;

	// a strictly earlier than b, modulo 2^TIME_W
	function automatic logic time_before(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

	function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

// ===== design/tofm_in_if.sv =====
// Input request channel of the flow mux: valid/ready plus item fields.
// Depends on tofm_pkg.
interface tofm_in_if;
	logic                             valid;
	logic                             ready;
	logic                             command;
	logic [tofm_pkg::FLOW_IN_W-1:0]   flow;
	logic [tofm_pkg::TIME_W-1:0]      out_time;
	logic [tofm_pkg::PAY_W-1:0]       payload;
	logic [tofm_pkg::TIME_W-1:0]      time_limit;
	logic [tofm_pkg::SPACE_W-1:0]     space;

	modport source (output valid, command, flow, out_time, payload, time_limit, space,
		input ready);
	modport sink (input valid, command, flow, out_time, payload, time_limit, space,
		output ready);
endinterface

// ===== design/tofm_out_if.sv =====
// Result channel of the flow mux: valid/ready plus result fields.
// Depends on tofm_pkg.
interface tofm_out_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       kind;
	logic [tofm_pkg::FLOW_IN_W-1:0]   src_flow;
	logic [tofm_pkg::TIME_W-1:0]      sel_time;
	logic [tofm_pkg::PAY_W-1:0]       sel_payload;
	logic                             push_refused;
	logic [tofm_pkg::CNT_W-1:0]       dropped_total;
	logic [tofm_pkg::CNT_W-1:0]       muxed_total;
	logic                             last;

	modport source (output valid, kind, src_flow, sel_time, sel_payload, push_refused,
		dropped_total, muxed_total, last, input ready);
	modport sink (input valid, kind, src_flow, sel_time, sel_payload, push_refused,
		dropped_total, muxed_total, last, output ready);
endinterface

// ===== design/tofm_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module tofm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/tofm_ctrl.sv =====
// Controller FSM of the flow mux: sequences push, drop, scan and emit steps.
// Depends on tofm_pkg; drives the datapath through ctrl_cmd_t.
module tofm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tofm_pkg::dp_stat_t   stat,
	output tofm_pkg::ctrl_cmd_t  cmd
);
	tofm_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tofm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			tofm_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_fire) begin
					state_d = stat.in_is_mux ? tofm_pkg::ST_DROP : tofm_pkg::ST_PUSH;
				end
			end
			tofm_pkg::ST_PUSH: begin
				if (stat.out_free) begin
					cmd.push_do = 1'b1;
					state_d     = tofm_pkg::ST_IDLE;
				end
			end
			tofm_pkg::ST_DROP: begin
				if (stat.cur_empty) begin
					cmd.clr_elig = 1'b1;
					if (stat.cur_last) begin
						state_d = tofm_pkg::ST_SCAN_START;
					end else begin
						cmd.cur_inc = 1'b1;
					end
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = tofm_pkg::ST_DROP_WAIT;
				end
			end
			tofm_pkg::ST_DROP_WAIT: begin
				if (stat.head_keep) begin
					cmd.set_elig = 1'b1;
					if (stat.cur_last) begin
						state_d = tofm_pkg::ST_SCAN_START;
					end else begin
						cmd.cur_inc = 1'b1;
						state_d     = tofm_pkg::ST_DROP;
					end
				end else begin
					cmd.drop = 1'b1;
					state_d  = tofm_pkg::ST_DROP;
				end
			end
			tofm_pkg::ST_SCAN_START: begin
				if (stat.space_left) begin
					cmd.scan_clr = 1'b1;
					state_d      = tofm_pkg::ST_SCAN;
				end else begin
					state_d = tofm_pkg::ST_DONE;
				end
			end
			tofm_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.cur_last) begin
					state_d = tofm_pkg::ST_PICK;
				end else begin
					cmd.cur_inc = 1'b1;
				end
			end
			tofm_pkg::ST_PICK: begin
				if (stat.best_valid) begin
					cmd.cur_best = 1'b1;
					state_d      = tofm_pkg::ST_READ;
				end else begin
					state_d = tofm_pkg::ST_DONE;
				end
			end
			tofm_pkg::ST_READ: begin
				cmd.rd_cur = 1'b1;
				state_d    = tofm_pkg::ST_EMIT;
			end
			tofm_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = tofm_pkg::ST_REFILL;
				end
			end
			tofm_pkg::ST_REFILL: begin
				if (stat.cur_empty) begin
					cmd.clr_elig = 1'b1;
					state_d      = tofm_pkg::ST_SCAN_START;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = tofm_pkg::ST_REFILL_WAIT;
				end
			end
			tofm_pkg::ST_REFILL_WAIT: begin
				cmd.set_elig = 1'b1;
				state_d      = tofm_pkg::ST_SCAN_START;
			end
			tofm_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.done_emit = 1'b1;
					state_d       = tofm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tofm_pkg::ST_IDLE;
			end
		endcase
	end
endmodule

// ===== design/tofm_dp.sv =====
// Datapath of the flow mux: entry RAM, ring pointers, head registers,
// min-select tracking, counters and the output register.
// Depends on tofm_pkg, tofm_ram, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"
module tofm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	tofm_in_if.sink                      in_ch,
	tofm_out_if.source                   out_ch,
	input  logic                         cfg_we,
	input  logic [tofm_pkg::TIME_W-1:0]  cfg_wdata,
	input  tofm_pkg::ctrl_cmd_t          cmd,
	output tofm_pkg::dp_stat_t           stat
);
	localparam int FLOW_W = tofm_pkg::FLOW_W;
	localparam int PTR_W  = tofm_pkg::PTR_W;
	localparam int ADDR_W = tofm_pkg::ADDR_W;
	localparam int TIME_W = tofm_pkg::TIME_W;
	localparam int PAY_W  = tofm_pkg::PAY_W;

	logic [PTR_W-1:0]        rp_q [tofm_pkg::FLOWS];
	logic [PTR_W-1:0]        wp_q [tofm_pkg::FLOWS];
	logic [tofm_pkg::FLOWS-1:0] elig_q;
	logic [TIME_W-1:0]       head_t_q [tofm_pkg::FLOWS];
	logic [FLOW_W-1:0]       cur_q;
	logic [FLOW_W-1:0]       best_q;
	logic [TIME_W-1:0]       best_t_q;
	logic                    best_valid_q;
	logic [tofm_pkg::SPACE_W-1:0] emitted_q;
	logic [tofm_pkg::SPACE_W-1:0] space_q;
	logic [TIME_W-1:0]       limit_q;
	logic [TIME_W-1:0]       past_q;
	logic [TIME_W-1:0]       window_q;
	logic [TIME_W-1:0]       push_t_q;
	logic [PAY_W-1:0]        push_p_q;
	logic                    flow_ok_q;
	logic [tofm_pkg::CNT_W-1:0] drop_q;
	logic [tofm_pkg::CNT_W-1:0] mux_q;
	logic                    ovalid_q;

	logic [1:0]              kind_q;
	logic [tofm_pkg::FLOW_IN_W-1:0] src_q;
	logic [TIME_W-1:0]       sel_t_q;
	logic [PAY_W-1:0]        sel_p_q;
	logic                    refused_q;
	logic [tofm_pkg::CNT_W-1:0] dtot_q;
	logic [tofm_pkg::CNT_W-1:0] mtot_q;
	logic                    last_q;

	logic                    in_fire;
	logic                    out_free;
	logic                    cur_full;
	logic                    push_wr;
	logic [ADDR_W-1:0]       base_addr;
	logic [ADDR_W-1:0]       rd_addr;
	logic [ADDR_W-1:0]       wr_addr;
	logic [tofm_pkg::ENTRY_W-1:0] ram_rdata;
	logic [TIME_W-1:0]       ram_t;
	logic [PAY_W-1:0]        ram_p;
	logic                    cand_better;

	assign in_fire   = in_ch.valid && cmd.in_ready;
	assign out_free  = !ovalid_q || out_ch.ready;
	assign cur_full  = tofm_pkg::ring_next(wp_q[cur_q]) == rp_q[cur_q];
	assign push_wr   = cmd.push_do && flow_ok_q && !cur_full;
	assign base_addr = ADDR_W'(cur_q) * ADDR_W'(tofm_pkg::RING_DEPTH);
	assign rd_addr   = base_addr + ADDR_W'(rp_q[cur_q]);
	assign wr_addr   = base_addr + ADDR_W'(wp_q[cur_q]);
	assign ram_t     = ram_rdata[tofm_pkg::ENTRY_W-1:PAY_W];
	assign ram_p     = ram_rdata[PAY_W-1:0];
	assign cand_better = elig_q[cur_q] &&
		(!best_valid_q || tofm_pkg::time_before(head_t_q[cur_q], best_t_q));

	tofm_ram #(
		.WIDTH (tofm_pkg::ENTRY_W),
		.DEPTH (tofm_pkg::FLOWS * tofm_pkg::RING_DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (push_wr),
		.waddr (wr_addr),
		.wdata ({push_t_q, push_p_q}),
		.re    (cmd.rd_cur),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// status toward the controller
	always_comb begin
		stat.in_fire    = in_fire;
		stat.in_is_mux  = in_ch.command == tofm_pkg::CMD_MUX;
		stat.cur_empty  = rp_q[cur_q] == wp_q[cur_q];
		stat.cur_last   = cur_q == FLOW_W'(tofm_pkg::FLOWS - 1);
		stat.head_keep  = tofm_pkg::time_before(past_q, ram_t);
		stat.best_valid = best_valid_q;
		stat.space_left = emitted_q < space_q;
		stat.out_free   = out_free;
	end

	// control state: pointers, flags, counters, window, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tofm_pkg::FLOWS; i++) begin
				rp_q[i] <= '0;
				wp_q[i] <= '0;
			end
			elig_q       <= '0;
			cur_q        <= '0;
			best_valid_q <= 1'b0;
			emitted_q    <= '0;
			drop_q       <= '0;
			mux_q        <= '0;
			window_q     <= tofm_pkg::WINDOW_RST;
			ovalid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			// cursor: push target, flow walk or chosen flow
			if (in_fire) begin
				cur_q     <= in_ch.command == tofm_pkg::CMD_MUX ? '0 : FLOW_W'(in_ch.flow);
				emitted_q <= '0;
			end else if (cmd.scan_clr) begin
				cur_q <= '0;
			end else if (cmd.cur_inc) begin
				cur_q <= cur_q + FLOW_W'(1);
			end else if (cmd.cur_best) begin
				cur_q <= best_q;
			end
			if (push_wr) begin
				wp_q[cur_q] <= tofm_pkg::ring_next(wp_q[cur_q]);
			end
			// advance head on drop or emit
			if (cmd.drop || cmd.emit) begin
				rp_q[cur_q] <= tofm_pkg::ring_next(rp_q[cur_q]);
			end
			if (cmd.drop) begin
				drop_q <= drop_q + tofm_pkg::CNT_W'(1);
			end
			if (cmd.emit) begin
				mux_q     <= mux_q + tofm_pkg::CNT_W'(1);
				emitted_q <= emitted_q + tofm_pkg::SPACE_W'(1);
			end
			if (cmd.set_elig) begin
				elig_q[cur_q] <= tofm_pkg::time_before(ram_t, limit_q);
			end else if (cmd.clr_elig) begin
				elig_q[cur_q] <= 1'b0;
			end
			if (cmd.scan_clr) begin
				best_valid_q <= 1'b0;
			end else if (cmd.scan_step && cand_better) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.push_do || cmd.emit || cmd.done_emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			limit_q   <= in_ch.time_limit;
			past_q    <= in_ch.time_limit - window_q;
			space_q   <= in_ch.space;
			push_t_q  <= in_ch.out_time;
			push_p_q  <= in_ch.payload;
			flow_ok_q <= 32'(in_ch.flow) < tofm_pkg::FLOWS;
		end
		if (cmd.set_elig) begin
			head_t_q[cur_q] <= ram_t;
		end
		// hold the earliest head seen so far in this scan
		if (cmd.scan_step && cand_better) begin
			best_q   <= cur_q;
			best_t_q <= head_t_q[cur_q];
		end
		if (cmd.push_do) begin
			kind_q    <= tofm_pkg::KIND_PUSH;
			src_q     <= '0;
			sel_t_q   <= '0;
			sel_p_q   <= '0;
			refused_q <= !(flow_ok_q && !cur_full);
			dtot_q    <= '0;
			mtot_q    <= '0;
			last_q    <= 1'b1;
		end else if (cmd.emit) begin
			kind_q    <= tofm_pkg::KIND_MUXED;
			src_q     <= tofm_pkg::FLOW_IN_W'(cur_q);
			sel_t_q   <= ram_t;
			sel_p_q   <= ram_p;
			refused_q <= 1'b0;
			dtot_q    <= '0;
			mtot_q    <= '0;
			last_q    <= 1'b0;
		end else if (cmd.done_emit) begin
			kind_q    <= tofm_pkg::KIND_DONE;
			src_q     <= '0;
			sel_t_q   <= '0;
			sel_p_q   <= '0;
			refused_q <= 1'b0;
			dtot_q    <= drop_q;
			mtot_q    <= mux_q;
			last_q    <= 1'b1;
		end
	end

	assign in_ch.ready         = cmd.in_ready;
	assign out_ch.valid        = ovalid_q;
	assign out_ch.kind         = kind_q;
	assign out_ch.src_flow     = src_q;
	assign out_ch.sel_time     = sel_t_q;
	assign out_ch.sel_payload  = sel_p_q;
	assign out_ch.push_refused = refused_q;
	assign out_ch.dropped_total = dtot_q;
	assign out_ch.muxed_total  = mtot_q;
	assign out_ch.last         = last_q;

	`ASSERT_PROP(a_emit_has_best, clk, arst_n, cmd.emit |-> best_valid_q)
	`ASSERT_PROP(a_load_needs_room, clk, arst_n,
		(cmd.push_do || cmd.emit || cmd.done_emit) |-> out_free)
	`ASSERT_PROP(a_one_load, clk, arst_n, $onehot0({cmd.push_do, cmd.emit, cmd.done_emit}))
	`ASSERT_NEVER(a_space_kept, clk, arst_n, cmd.emit && !(emitted_q < space_q))
endmodule

// ===== design/timestamp_ordered_flow_mux_unit.sv =====
// Timestamp ordered flow mux: eight ring FIFOs of timed commands merged by
// earliest wrap-aware time. A push is accepted, then loads its result once
// the result register is free. A mux pass first walks the flows once,
// reading each head it examines from the entry RAM and dropping overdue
// heads; each muxed command then takes a scan of the head-time registers,
// one flow per cycle, a pick, a read of the chosen head through the single
// entry RAM read port, the emit, and a read back of the flow's next head
// when it holds one; closing the pass takes a last scan (skipped when the
// space is used up) plus the done result, each result waiting for the result
// register when it is busy. One item is in work at a time.
// Depends on tofm_pkg, the channel interfaces, tofm_ctrl and tofm_dp.
module timestamp_ordered_flow_mux_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	tofm_in_if.sink                      in_ch,
	tofm_out_if.source                   out_ch,
	input  logic                         cfg_we,
	input  logic [tofm_pkg::TIME_W-1:0]  cfg_wdata
);
	tofm_pkg::ctrl_cmd_t cmd;
	tofm_pkg::dp_stat_t  stat;

	tofm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	tofm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);
endmodule

// ===== dv/tofm_tb_if.sv =====
// Testbench-side note: the channel interfaces come from the design folder.
// This file holds the small helper package of the flow mux testbench.
// Depends on tofm_pkg.
`timescale 1ns / 1ps
package tofm_tb_pkg;
	import tofm_pkg::*;

	typedef struct packed {
		logic [1:0]        kind;
		logic [2:0]        src_flow;
		logic [TIME_W-1:0] sel_time;
		logic [PAY_W-1:0]  sel_payload;
		logic              push_refused;
		logic [CNT_W-1:0]  dropped_total;
		logic [CNT_W-1:0]  muxed_total;
		logic              last;
	} mux_result_t;
endpackage

// ===== dv/testbench.sv =====
// Testbench for timestamp_ordered_flow_mux_unit: drives push and mux requests,
// predicts every result with a local model of the flow rings, checks in order.
// Depends on tofm_pkg, tofm_tb_pkg, tofm_in_if, tofm_out_if and the RTL.
`timescale 1ns / 1ps
module testbench;
	import tofm_pkg::*;
	import tofm_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [TIME_W-1:0] cfg_wdata = '0;

	tofm_in_if in_ch ();
	tofm_out_if out_ch ();

	timestamp_ordered_flow_mux_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// model state
	logic [TIME_W-1:0] ring_time [FLOWS][RING_DEPTH];
	logic [PAY_W-1:0]  ring_pay [FLOWS][RING_DEPTH];
	logic [PTR_W-1:0]  rd_ptr [FLOWS];
	logic [PTR_W-1:0]  wr_ptr [FLOWS];
	logic [CNT_W-1:0]  drop_count;
	logic [CNT_W-1:0]  mux_count;
	logic [TIME_W-1:0] window;

	mux_result_t expected_results[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit sink_stalls = 1'b1;

	function automatic logic earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

	function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
		return p + PTR_W'(1);
	endfunction

	// compute the results one request causes and queue them
	function automatic void predict(logic cmd, logic [2:0] fl, logic [TIME_W-1:0] t,
			logic [PAY_W-1:0] pay, logic [TIME_W-1:0] lim, logic [SPACE_W-1:0] sp);
		mux_result_t r;
		logic elig [FLOWS];
		logic [TIME_W-1:0] past, bt;
		int best, emitted;
		r = '0;
		if (cmd == CMD_PUSH) begin
			r.kind = KIND_PUSH;
			r.last = 1'b1;
			r.push_refused = 1'b1;
			if (advance(wr_ptr[fl]) != rd_ptr[fl]) begin
				ring_time[fl][wr_ptr[fl]] = t;
				ring_pay[fl][wr_ptr[fl]] = pay;
				wr_ptr[fl] = advance(wr_ptr[fl]);
				r.push_refused = 1'b0;
			end
			expected_results.push_back(r);
			return;
		end
		past = lim - window;
		// drop overdue heads
		for (int f = 0; f < FLOWS; f++) begin
			elig[f] = 1'b0;
			while (rd_ptr[f] != wr_ptr[f]) begin
				if (earlier(past, ring_time[f][rd_ptr[f]])) begin
					elig[f] = earlier(ring_time[f][rd_ptr[f]], lim);
					break;
				end
				rd_ptr[f] = advance(rd_ptr[f]);
				drop_count++;
			end
		end
		// emit earliest heads
		emitted = 0;
		while (emitted < sp) begin
			best = -1;
			bt = '0;
			for (int f = 0; f < FLOWS; f++)
				if (elig[f] && (best < 0 || earlier(ring_time[f][rd_ptr[f]], bt))) begin
					best = f;
					bt = ring_time[f][rd_ptr[f]];
				end
			if (best < 0)
				break;
			r = '0;
			r.kind = KIND_MUXED;
			r.src_flow = best[2:0];
			r.sel_time = bt;
			r.sel_payload = ring_pay[best][rd_ptr[best]];
			expected_results.push_back(r);
			mux_count++;
			emitted++;
			rd_ptr[best] = advance(rd_ptr[best]);
			elig[best] = rd_ptr[best] != wr_ptr[best] &&
				earlier(ring_time[best][rd_ptr[best]], lim);
		end
		r = '0;
		r.kind = KIND_DONE;
		r.dropped_total = drop_count;
		r.muxed_total = mux_count;
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// send one request, predicting on acceptance; starts and ends at a falling edge
	task automatic send_request(logic cmd, logic [2:0] fl, logic [TIME_W-1:0] t,
			logic [PAY_W-1:0] pay, logic [TIME_W-1:0] lim, logic [SPACE_W-1:0] sp,
			bit with_gaps = 1'b1);
		int g;
		g = with_gaps ? gap_length() : 0;
		// drop the request line over an idle gap
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.flow <= fl;
		in_ch.out_time <= t;
		in_ch.payload <= pay;
		in_ch.time_limit <= lim;
		in_ch.space <= sp;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict(cmd, fl, t, pay, lim, sp);
		@(negedge clk);
	endtask

	task automatic push_cmd(logic [2:0] fl, logic [TIME_W-1:0] t, logic [PAY_W-1:0] pay);
		send_request(CMD_PUSH, fl, t, pay, TIME_W'($urandom), SPACE_W'($urandom));
	endtask

	task automatic mux_pass(logic [TIME_W-1:0] lim, logic [SPACE_W-1:0] sp);
		send_request(CMD_MUX, 3'($urandom), TIME_W'($urandom), $urandom, lim, sp);
	endtask

	// drop the request line, wait for all results, then let a mux pass settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_window(logic [TIME_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		window = value;
	endtask

	// sink side: random stalls, sample at rising edge
	always @(negedge clk) begin
		if (sink_stalls && $urandom_range(0, 99) < 30)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= 1'b1;
	end

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		mux_result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.kind, out_ch.src_flow, out_ch.sel_time, out_ch.sel_payload,
				out_ch.push_refused, out_ch.dropped_total, out_ch.muxed_total,
				out_ch.last};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timestamp_ordered_flow_mux_unit test failed");
			$finish;
		end
	end

	task automatic test_directed();
		// fill flow 0 to refusal, extremes of fields
		for (int i = 0; i < RING_DEPTH; i++)
			push_cmd(3'd0, TIME_W'(100 + i), (i == 0) ? '1 : PAY_W'(i));
		push_cmd(3'd7, '1, '0);
		push_cmd(3'd3, TIME_W'(100), 32'hA5A5_5A5A);
		push_cmd(3'd5, TIME_W'(100), 32'h5A5A_A5A5);
		// space zero: drops only
		mux_pass(TIME_W'(103), '0);
		// tie resolves to lowest flow, limited space
		mux_pass(TIME_W'(200), 6'd3);
		mux_pass(TIME_W'(200), '1);
		// drop everything overdue
		push_cmd(3'd2, TIME_W'(10), 32'h1);
		push_cmd(3'd2, TIME_W'(20000), 32'h2);
		mux_pass(TIME_W'(9000), 6'd63);
		mux_pass('0, 6'd63);
		// wrap across zero
		push_cmd(3'd4, 24'hFFFFF0, 32'h3);
		push_cmd(3'd4, 24'h000010, 32'h4);
		mux_pass(24'h000020, 6'd63);
	endtask

	task automatic test_random(int items);
		logic [TIME_W-1:0] base;
		base = TIME_W'($urandom);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 99) < 70)
				push_cmd(3'($urandom), base + TIME_W'($urandom_range(0, 3000)) -
					(($urandom_range(0, 9) == 0) ? TIME_W'($urandom) : '0), $urandom);
			else begin
				mux_pass(base + TIME_W'($urandom_range(0, 4000)),
					($urandom_range(0, 3) == 0) ? SPACE_W'($urandom) :
					SPACE_W'($urandom_range(0, 6)));
				base = base + TIME_W'($urandom_range(0, 1500));
			end
		end
	endtask

	task automatic test_back_to_back();
		sink_stalls = 1'b0;
		for (int i = 0; i < 12; i++)
			send_request(CMD_PUSH, 3'($urandom), TIME_W'($urandom_range(0, 50)), $urandom,
				'0, '0, 1'b0);
		send_request(CMD_MUX, '0, '0, '0, TIME_W'(60), '1, 1'b0);
		drain();
		sink_stalls = 1'b1;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_PUSH;
		in_ch.flow = '0;
		in_ch.out_time = '0;
		in_ch.payload = '0;
		in_ch.time_limit = '0;
		in_ch.space = '0;
		out_ch.ready = 1'b0;
		for (int f = 0; f < FLOWS; f++) begin
			rd_ptr[f] = '0;
			wr_ptr[f] = '0;
		end
		drop_count = '0;
		mux_count = '0;
		window = WINDOW_RST;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(70);
		write_window('0);
		test_random(30);
		write_window('1);
		test_random(30);
		write_window(TIME_W'(500));
		test_back_to_back();
		test_random(46);
		drain();

		if (mismatches == 0 && expected_results.size() == 0)
			$display("timestamp_ordered_flow_mux_unit test passed");
		else
			$display("timestamp_ordered_flow_mux_unit test failed");
		$finish;
	end
endmodule
